// ===== rtl/core/pbfs_pkg.sv =====
// Shared widths, codes, defaults and the descriptor type of the packed bit-field store.
package pbfs_pkg;

    localparam int OP_W       = 3;
    localparam int ENTRY_W    = 12;
    localparam int VALUE_W    = 32;
    localparam int BANK_W     = 2;
    localparam int START_W    = 12;
    localparam int WLO_W      = 5;
    localparam int TASK_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int NUM_BANKS  = 4;

    localparam int DEF_TABLE_DEPTH = 4096;
    localparam int DEF_BANK_BITS   = 4096;

    localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
    localparam logic [OP_W-1:0] OP_READ  = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 3'd2;
    localparam logic [OP_W-1:0] OP_INC   = 3'd3;
    localparam logic [OP_W-1:0] OP_DEC   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SPECIAL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT     = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_SIZE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_ENTRY   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_ENTRY  = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RST_TABLE_SIZE = 13'd0;
    localparam logic [ENTRY_W-1:0]    RST_ONE_ENTRY  = 12'd4095;
    localparam logic [ENTRY_W-1:0]    RST_ZERO_ENTRY = 12'd4094;

    typedef struct packed {
        logic [BANK_W-1:0]  bank;
        logic [START_W-1:0] start;
        logic [WLO_W-1:0]   wlo;
        logic               notify;
        logic [TASK_W-1:0]  task_id;
    } desc_t;

endpackage

// ===== rtl/core/pbfs_desc_ram.sv =====
// Single-port descriptor table memory with registered read data.
module pbfs_desc_ram #(
    parameter int TABLE_DEPTH = pbfs_pkg::DEF_TABLE_DEPTH
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [$clog2(TABLE_DEPTH)-1:0] addr,
    input  pbfs_pkg::desc_t                wdata,
    output pbfs_pkg::desc_t                rdata
);
    import pbfs_pkg::*;

    desc_t mem_reg [TABLE_DEPTH];
    desc_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/pbfs_bank_ram.sv =====
// One-bit-wide flag bank memory with a clearing sweep after reset.
module pbfs_bank_ram #(
    parameter int BANK_BITS = pbfs_pkg::DEF_BANK_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           we,
    input  logic [$clog2(BANK_BITS)+1:0]   addr,
    input  logic                           wbit,
    output logic                           rbit,
    output logic                           clearing
);
    import pbfs_pkg::*;

    localparam int ADDR_W = $clog2(BANK_BITS) + 2;
    localparam int DEPTH  = 1 << ADDR_W;

    logic              mem_reg [DEPTH];
    logic              rbit_reg;
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    // The sweep writes one zero per cycle until every address is covered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == {ADDR_W{1'b1}})
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem_reg[clr_cnt_reg] <= 1'b0;
        end
        else if (en && we)
        begin
            mem_reg[addr] <= wbit;
        end
        if (en && !we)
        begin
            rbit_reg <= mem_reg[addr];
        end
    end

    assign rbit     = rbit_reg;
    assign clearing = clearing_reg;

endmodule

// ===== rtl/core/packed_bit_field_store_core.sv =====
// Top level of the packed bit-field store: command decode, bit-serial field sequencer, registers.
//
// A word is accepted when start is high while busy is low, and its single result word appears
// on the result ports for exactly one cycle with done high; the receiver cannot stall it. A
// descriptor load, an unknown operation, a special entry or an out-of-range entry is answered
// in the cycle after acceptance and busy stays low, so such words can come every cycle. Field
// accesses run one bit per cycle through a one-bit-wide bank memory, so their cost follows the
// field width w (1 to 32) of the addressed descriptor: a read fetches the descriptor and reads
// w bits, a write writes w bits, and an increment or decrement reads the field and then writes
// it back unless it saturates, when it stops after the read; the result is shown in the cycle in
// which busy falls, when the next word may already be accepted. After reset the flag banks are
// cleared by a sweep over every bank address during which busy is high; configuration writes
// are taken at any time.
module packed_bit_field_store_core #(
    parameter int TABLE_DEPTH = pbfs_pkg::DEF_TABLE_DEPTH,
    parameter int BANK_BITS   = pbfs_pkg::DEF_BANK_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [pbfs_pkg::OP_W-1:0]          operation,
    input  logic [pbfs_pkg::ENTRY_W-1:0]       entry,
    input  logic [pbfs_pkg::VALUE_W-1:0]       write_value,
    input  logic [pbfs_pkg::BANK_W-1:0]        desc_bank,
    input  logic [pbfs_pkg::START_W-1:0]       desc_start,
    input  logic [pbfs_pkg::WLO_W-1:0]         desc_width_less_one,
    input  logic                               desc_notify,
    input  logic [pbfs_pkg::TASK_W-1:0]        desc_task,
    output logic                               done,
    output logic [pbfs_pkg::VALUE_W-1:0]       read_value,
    output logic                               task_done_valid,
    output logic [pbfs_pkg::TASK_W-1:0]        task_done_id,
    output logic [pbfs_pkg::STATUS_W-1:0]      status,
    input  logic                               cfg_write,
    input  logic [pbfs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pbfs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pbfs_pkg::*;

    localparam int TAW   = $clog2(TABLE_DEPTH);
    localparam int BAW   = $clog2(BANK_BITS);
    // Bit positions reach start + 31, so the position counter covers both that and BANK_BITS.
    localparam int POS_W = ((BAW > START_W) ? BAW : START_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DESC,
        S_READ,
        S_DRAIN,
        S_EVAL,
        S_WRITE,
        S_FIN
    } state_t;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] table_size_reg;
    logic [ENTRY_W-1:0]    one_entry_reg;
    logic [ENTRY_W-1:0]    zero_entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= RST_TABLE_SIZE;
            one_entry_reg  <= RST_ONE_ENTRY;
            zero_entry_reg <= RST_ZERO_ENTRY;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TABLE_SIZE: table_size_reg <= cfg_data;
                CFG_ONE_ENTRY:  one_entry_reg  <= cfg_data[ENTRY_W-1:0];
                CFG_ZERO_ENTRY: zero_entry_reg <= cfg_data[ENTRY_W-1:0];
                default:        ;
            endcase
        end
    end

    // Sequencer and datapath registers.
    state_t               state_reg,      state_next;
    logic [OP_W-1:0]      op_reg,         op_next;
    logic [VALUE_W-1:0]   src_reg,        src_next;
    logic [VALUE_W-1:0]   cur_reg,        cur_next;
    logic [VALUE_W-1:0]   res_reg,        res_next;
    logic [BANK_W-1:0]    bank_reg,       bank_next;
    logic [START_W-1:0]   start_reg,      start_next;
    logic [POS_W-1:0]     pos_reg,        pos_next;
    logic [WLO_W-1:0]     wlo_reg,        wlo_next;
    logic [WLO_W-1:0]     cnt_reg,        cnt_next;
    logic                 notify_reg,     notify_next;
    logic [TASK_W-1:0]    task_reg,       task_next;
    logic                 ones_reg,       ones_next;
    logic                 zero_reg,       zero_next;
    logic                 carry_reg,      carry_next;
    logic                 cap_valid_reg,  cap_valid_next;
    logic [WLO_W-1:0]     cap_idx_reg,    cap_idx_next;
    logic                 cap_inb_reg,    cap_inb_next;
    logic                 done_reg,       done_next;
    logic [VALUE_W-1:0]   read_value_reg, read_value_next;
    logic                 tdv_reg,        tdv_next;
    logic [TASK_W-1:0]    tdid_reg,       tdid_next;
    logic [STATUS_W-1:0]  status_reg,     status_next;

    // Memory interfaces.
    logic                 desc_we;
    logic [TAW-1:0]       desc_addr;
    desc_t                desc_wdata;
    desc_t                desc_rdata;
    logic                 bank_en;
    logic                 bank_we;
    logic [BAW+1:0]       bank_addr;
    logic                 bank_wbit;
    logic                 bank_rbit;
    logic                 clearing;

    logic                 accept;
    logic                 in_table;
    logic                 out_of_range;
    logic                 pos_in_bank;
    logic                 cap_bit;
    logic                 ser_bit;
    logic                 new_bit;

    assign busy   = clearing || (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Entry checks for the word at the ports.
    assign in_table     = 32'(entry) < 32'(TABLE_DEPTH);
    assign out_of_range = !in_table || ({1'b0, entry} >= table_size_reg);

    assign desc_we    = accept && (operation == OP_LOAD) && in_table;
    assign desc_addr  = TAW'(entry);
    assign desc_wdata = '{bank: desc_bank, start: desc_start, wlo: desc_width_less_one,
                          notify: desc_notify, task_id: desc_task};

    assign pos_in_bank = pos_reg < POS_W'(BANK_BITS);
    assign bank_addr   = {bank_reg, pos_reg[BAW-1:0]};

    // A bit that was read from beyond the bank edge counts as zero.
    assign cap_bit = cap_inb_reg && bank_rbit;

    // Serial arithmetic: the carry of an increment or the borrow of a decrement ripples
    // one bit per cycle, starting at the least significant bit.
    assign ser_bit = src_reg[0];
    assign new_bit = (op_reg == OP_WRITE) ? ser_bit : (ser_bit ^ carry_reg);

    pbfs_desc_ram #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_desc_ram (
        .clk   (clk),
        .we    (desc_we),
        .addr  (desc_addr),
        .wdata (desc_wdata),
        .rdata (desc_rdata)
    );

    pbfs_bank_ram #(
        .BANK_BITS(BANK_BITS)
    ) u_bank_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (bank_en),
        .we       (bank_we),
        .addr     (bank_addr),
        .wbit     (bank_wbit),
        .rbit     (bank_rbit),
        .clearing (clearing)
    );

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        src_next        = src_reg;
        cur_next        = cur_reg;
        res_next        = res_reg;
        bank_next       = bank_reg;
        start_next      = start_reg;
        pos_next        = pos_reg;
        wlo_next        = wlo_reg;
        cnt_next        = cnt_reg;
        notify_next     = notify_reg;
        task_next       = task_reg;
        ones_next       = ones_reg;
        zero_next       = zero_reg;
        carry_next      = carry_reg;
        cap_valid_next  = 1'b0;
        cap_idx_next    = cnt_reg;
        cap_inb_next    = pos_in_bank;
        done_next       = 1'b0;
        read_value_next = '0;
        tdv_next        = 1'b0;
        tdid_next       = '0;
        status_next     = ST_OK;
        bank_en         = 1'b0;
        bank_we         = 1'b0;
        bank_wbit       = new_bit;

        // The read data of a bit issued in the previous cycle is folded in here.
        if (cap_valid_reg)
        begin
            cur_next[cap_idx_reg] = cap_bit;
            ones_next             = ones_reg && cap_bit;
            zero_next             = zero_reg && !cap_bit;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = operation;
                    src_next = write_value;
                    if (operation == OP_LOAD)
                    begin
                        done_next   = 1'b1;
                        status_next = in_table ? ST_OK : ST_SPECIAL;
                    end
                    else if (operation > OP_DEC)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_SPECIAL;
                    end
                    else if ((entry == one_entry_reg) || (entry == zero_entry_reg))
                    begin
                        // The fixed-one entry wins when both registers name the same entry.
                        done_next   = 1'b1;
                        status_next = ST_SPECIAL;
                        if ((operation != OP_WRITE) && (entry == one_entry_reg))
                        begin
                            read_value_next = VALUE_W'(1);
                        end
                    end
                    else if (out_of_range)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_SPECIAL;
                    end
                    else
                    begin
                        state_next = S_DESC;
                    end
                end
            end

            S_DESC:
            begin
                bank_next   = desc_rdata.bank;
                start_next  = desc_rdata.start;
                pos_next    = POS_W'(desc_rdata.start);
                wlo_next    = desc_rdata.wlo;
                notify_next = desc_rdata.notify;
                task_next   = desc_rdata.task_id;
                cnt_next    = '0;
                cur_next    = '0;
                res_next    = '0;
                ones_next   = 1'b1;
                zero_next   = 1'b1;
                carry_next  = 1'b1;
                // A plain write needs no look at the old field.
                state_next  = (op_reg == OP_WRITE) ? S_WRITE : S_READ;
            end

            S_READ:
            begin
                bank_en        = pos_in_bank;
                cap_valid_next = 1'b1;
                pos_next       = pos_reg + 1'b1;
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == wlo_reg)
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                pos_next   = POS_W'(start_reg);
                cnt_next   = '0;
                src_next   = cur_reg;
                carry_next = 1'b1;
                if (op_reg == OP_READ)
                begin
                    done_next       = 1'b1;
                    read_value_next = cur_reg;
                    state_next      = S_IDLE;
                end
                else if ((op_reg == OP_INC) && ones_reg)
                begin
                    done_next       = 1'b1;
                    read_value_next = cur_reg;
                    status_next     = ST_SAT;
                    state_next      = S_IDLE;
                end
                else if ((op_reg == OP_DEC) && zero_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_SAT;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end

            S_WRITE:
            begin
                bank_en           = pos_in_bank;
                bank_we           = 1'b1;
                res_next[cnt_reg] = new_bit;
                src_next          = src_reg >> 1;
                carry_next        = (op_reg == OP_INC) ? (ser_bit && carry_reg)
                                                       : (!ser_bit && carry_reg);
                pos_next          = pos_reg + 1'b1;
                cnt_next          = cnt_reg + 1'b1;
                if (cnt_reg == wlo_reg)
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                done_next       = 1'b1;
                read_value_next = (op_reg == OP_WRITE) ? '0 : res_reg;
                tdv_next        = notify_reg;
                tdid_next       = notify_reg ? task_reg : '0;
                state_next      = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_LOAD;
            src_reg        <= '0;
            cur_reg        <= '0;
            res_reg        <= '0;
            bank_reg       <= '0;
            start_reg      <= '0;
            pos_reg        <= '0;
            wlo_reg        <= '0;
            cnt_reg        <= '0;
            notify_reg     <= 1'b0;
            task_reg       <= '0;
            ones_reg       <= 1'b0;
            zero_reg       <= 1'b0;
            carry_reg      <= 1'b0;
            cap_valid_reg  <= 1'b0;
            cap_idx_reg    <= '0;
            cap_inb_reg    <= 1'b0;
            done_reg       <= 1'b0;
            read_value_reg <= '0;
            tdv_reg        <= 1'b0;
            tdid_reg       <= '0;
            status_reg     <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            src_reg        <= src_next;
            cur_reg        <= cur_next;
            res_reg        <= res_next;
            bank_reg       <= bank_next;
            start_reg      <= start_next;
            pos_reg        <= pos_next;
            wlo_reg        <= wlo_next;
            cnt_reg        <= cnt_next;
            notify_reg     <= notify_next;
            task_reg       <= task_next;
            ones_reg       <= ones_next;
            zero_reg       <= zero_next;
            carry_reg      <= carry_next;
            cap_valid_reg  <= cap_valid_next;
            cap_idx_reg    <= cap_idx_next;
            cap_inb_reg    <= cap_inb_next;
            done_reg       <= done_next;
            read_value_reg <= read_value_next;
            tdv_reg        <= tdv_next;
            tdid_reg       <= tdid_next;
            status_reg     <= status_next;
        end
    end

    assign done            = done_reg;
    assign read_value      = read_value_reg;
    assign task_done_valid = tdv_reg;
    assign task_done_id    = tdid_reg;
    assign status          = status_reg;

endmodule
